>>> sv/lca_pkg.sv
// lca_pkg: shared widths, action codes and sequencer states of the
// binary-lifting lowest-common-ancestor block
// no dependencies
package lca_pkg;

	localparam int ACT_W   = 2;
	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 10;
	localparam int CNT_W   = 11;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_QUERY = 2'd2
	} lca_action_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_B_RD1,
		S_B_RD2,
		S_B_WR,
		S_Q_RDD,
		S_Q_DEP,
		S_Q_TOP,
		S_Q_JMPT,
		S_Q_BIT,
		S_Q_JMPB,
		S_Q_EQ,
		S_Q_UPT,
		S_Q_UPTW,
		S_Q_UPB,
		S_Q_UPBW,
		S_Q_FIN,
		S_Q_FINW,
		S_RESP
	} lca_state_t;

endpackage

>>> sv/lca_if.sv
// lca_req_if, lca_rsp_if, lca_cfg_if: valid/ready channels of the
// lowest-common-ancestor block
// depends on lca_pkg
interface lca_req_if import lca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [NODE_W-1:0]  first_node;
	logic [NODE_W-1:0]  second_node;
	logic [NODE_W-1:0]  parent_node;
	logic               is_root;
	logic [DEPTH_W-1:0] node_depth;

	modport source (output valid, action, first_node, second_node, parent_node, is_root,
		node_depth, input ready);
	modport sink (input valid, action, first_node, second_node, parent_node, is_root,
		node_depth, output ready);
endinterface

interface lca_rsp_if import lca_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] ancestor;
	logic              found;

	modport source (output valid, ancestor, found, input ready);
	modport sink (input valid, ancestor, found, output ready);
endinterface

interface lca_cfg_if import lca_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> sv/lca_binary_lifting_top.sv
// lca_binary_lifting_top: lowest common ancestor on a rooted forest by binary lifting
// one sequencer over a two-read-port ancestor table memory and a depth memory
// depends on lca_pkg and lca_if
//
// channels: req (sink) takes one word per item: load, build or query;
// rsp (source) gives one word per query: ancestor and found; cfg (sink) writes
// node_count and is always ready. node_count must be written only while the block is
// idle; the block itself does not enforce it. a load writes the level-zero table entry
// and the depth of its node. a build walks every node at each level above zero, reading
// its entry at the level below and, where that names an ancestor, that ancestor's entry,
// then writing the result; the walk is serial through the table port. a query reads
// both depths, orders the nodes by depth, lifts the deeper one by top-level jumps and
// then by a bit scan from the top level down, and checks equality; unless the nodes
// meet there, it takes shared top-level jumps until a check ends them, descends
// through every level and checks the last parent, then loads the answer word.
// req is not ready while a build or query runs. a finished result sits in the rsp
// output register; req takes new items while it waits, but a later query holds
// until that register is free. reset: node_count returns to 1 and the table counts
// as not built (queries answer found 0 until a build); memories hold no reset value.
module lca_binary_lifting_top import lca_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  logic    clk,
	input  logic    arst_n,
	lca_req_if.sink   req,
	lca_rsp_if.source rsp,
	lca_cfg_if.sink   cfg
);

	localparam int NW        = $clog2(MAX_NODES);
	localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW        = NW + 1;
	localparam int AW        = LW + NW;
	localparam int TBL_DEPTH = LEVELS * (2 ** NW);
	localparam int TOP_POW   = 2 ** (LEVELS - 1);
	localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);

	lca_state_t state_q, state_d;

	logic [CNT_W-1:0]   cfg_q;
	logic [CW-1:0]      cnt;
	logic               built_q, built_d;
	logic [NW-1:0]      p_q, p_d, q_q, q_d;
	logic [DEPTH_W-1:0] diff_q, diff_d;
	logic [LW-1:0]      lvl_q, lvl_d;
	logic [CW-1:0]      gd_q, gd_d;
	logic [NW-1:0]      bi_q, bi_d;
	logic [LW-1:0]      bj_q, bj_d;
	logic [NW-1:0]      res_q, res_d;
	logic               ok_q, ok_d;
	logic               rsp_valid_q;
	logic [NODE_W-1:0]  rsp_anc_q;
	logic               rsp_found_q;
	logic               rsp_load;

	logic [NW:0]        tbl_mem [TBL_DEPTH];
	logic               tbl_we;
	logic [AW-1:0]      tbl_waddr, tbl_ra, tbl_rb;
	logic [NW:0]        tbl_wdata, tbl_da_q, tbl_db_q;

	logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
	logic               dep_we;
	logic [DEPTH_W-1:0] dep_dp_q, dep_dq_q;

	logic               accept;
	logic               n1_ok, par_ok, q_ok;
	logic               diff_big, diff_bit, gd_ok, last_node, last_lvl;
	logic [LW-1:0]      bj_prev;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign cnt = (32'(cfg_q) > MAX_NODES) ? CW'(MAX_NODES) : CW'(cfg_q);

	assign n1_ok     = 32'(req.first_node) < MAX_NODES;
	assign par_ok    = !req.is_root && (32'(req.parent_node) < MAX_NODES);
	assign q_ok      = built_q && (32'(req.first_node) < 32'(cnt))
		&& (32'(req.second_node) < 32'(cnt));
	assign diff_big  = 32'(diff_q) >= TOP_POW;
	assign diff_bit  = |((32'(diff_q) >> lvl_q) & 32'd1);
	assign gd_ok     = 32'(gd_q) < MAX_NODES;
	assign last_node = (32'(bi_q) + 32'd1) >= 32'(cnt);
	assign last_lvl  = (32'(bj_q) + 32'd1) >= LEVELS;
	assign bj_prev   = LW'(bj_q - LW'(1));

	always_comb begin
		state_d   = state_q;
		built_d   = built_q;
		p_d       = p_q;
		q_d       = q_q;
		diff_d    = diff_q;
		lvl_d     = lvl_q;
		gd_d      = gd_q;
		bi_d      = bi_q;
		bj_d      = bj_q;
		res_d     = res_q;
		ok_d      = ok_q;
		rsp_load  = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = {bj_q, bi_q};
		tbl_wdata = tbl_da_q;
		tbl_ra    = {lvl_q, p_q};
		tbl_rb    = {lvl_q, q_q};
		dep_we    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				tbl_waddr = {LW'(0), NW'(req.first_node)};
				tbl_wdata = par_ok ? {1'b1, NW'(req.parent_node)} : '0;
				if (accept) begin
					unique case (req.action)
						ACT_LOAD: begin
							if (n1_ok) begin
								tbl_we  = 1'b1;
								dep_we  = 1'b1;
								built_d = 1'b0;
							end
						end
						ACT_BUILD: begin
							if (cnt == '0 || LEVELS == 1) begin
								built_d = 1'b1;
							end else begin
								bi_d    = '0;
								bj_d    = LW'(1);
								state_d = S_B_RD1;
							end
						end
						ACT_QUERY: begin
							p_d   = NW'(req.first_node);
							q_d   = NW'(req.second_node);
							res_d = '0;
							ok_d  = 1'b0;
							if (q_ok) begin
								state_d = S_Q_RDD;
							end else begin
								state_d = S_RESP;
							end
						end
						default: ;
					endcase
				end
			end
			S_B_RD1: begin
				tbl_ra  = {bj_prev, bi_q};
				state_d = S_B_RD2;
			end
			S_B_RD2: begin
				tbl_ra = {bj_prev, tbl_da_q[NW-1:0]};
				if (tbl_da_q[NW]) begin
					state_d = S_B_WR;
				end else begin
					tbl_we    = 1'b1;
					tbl_wdata = '0;
					state_d   = S_B_RD1;
					if (last_node) begin
						bi_d = '0;
						bj_d = LW'(bj_q + LW'(1));
						if (last_lvl) begin
							built_d = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						bi_d = NW'(bi_q + NW'(1));
					end
				end
			end
			S_B_WR: begin
				tbl_we    = 1'b1;
				tbl_wdata = tbl_da_q;
				state_d   = S_B_RD1;
				if (last_node) begin
					bi_d = '0;
					bj_d = LW'(bj_q + LW'(1));
					if (last_lvl) begin
						built_d = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					bi_d = NW'(bi_q + NW'(1));
				end
			end
			S_Q_RDD: begin
				state_d = S_Q_DEP;
			end
			S_Q_DEP: begin
				if (dep_dp_q < dep_dq_q) begin
					p_d    = q_q;
					q_d    = p_q;
					diff_d = dep_dq_q - dep_dp_q;
				end else begin
					diff_d = dep_dp_q - dep_dq_q;
				end
				gd_d    = '0;
				state_d = S_Q_TOP;
			end
			S_Q_TOP: begin
				tbl_ra = {TOP, p_q};
				if (diff_big) begin
					if (gd_ok) begin
						gd_d    = CW'(gd_q + CW'(1));
						state_d = S_Q_JMPT;
					end else begin
						state_d = S_RESP;
					end
				end else begin
					lvl_d   = TOP;
					state_d = S_Q_BIT;
				end
			end
			S_Q_JMPT: begin
				if (tbl_da_q[NW]) begin
					p_d     = tbl_da_q[NW-1:0];
					diff_d  = DEPTH_W'(32'(diff_q) - TOP_POW);
					state_d = S_Q_TOP;
				end else begin
					state_d = S_RESP;
				end
			end
			S_Q_BIT: begin
				if (diff_bit) begin
					state_d = S_Q_JMPB;
				end else if (lvl_q == '0) begin
					state_d = S_Q_EQ;
				end else begin
					lvl_d = LW'(lvl_q - LW'(1));
				end
			end
			S_Q_JMPB: begin
				if (tbl_da_q[NW]) begin
					p_d = tbl_da_q[NW-1:0];
					if (lvl_q == '0) begin
						state_d = S_Q_EQ;
					end else begin
						lvl_d   = LW'(lvl_q - LW'(1));
						state_d = S_Q_BIT;
					end
				end else begin
					state_d = S_RESP;
				end
			end
			S_Q_EQ: begin
				if (p_q == q_q) begin
					res_d   = p_q;
					ok_d    = 1'b1;
					state_d = S_RESP;
				end else begin
					gd_d    = '0;
					state_d = S_Q_UPT;
				end
			end
			S_Q_UPT: begin
				tbl_ra = {TOP, p_q};
				tbl_rb = {TOP, q_q};
				if (gd_ok) begin
					gd_d    = CW'(gd_q + CW'(1));
					state_d = S_Q_UPTW;
				end else begin
					lvl_d   = TOP;
					state_d = S_Q_UPB;
				end
			end
			S_Q_UPTW: begin
				if (!tbl_da_q[NW] || !tbl_db_q[NW] || tbl_da_q == tbl_db_q) begin
					lvl_d   = TOP;
					state_d = S_Q_UPB;
				end else begin
					p_d     = tbl_da_q[NW-1:0];
					q_d     = tbl_db_q[NW-1:0];
					state_d = S_Q_UPT;
				end
			end
			S_Q_UPB: begin
				state_d = S_Q_UPBW;
			end
			S_Q_UPBW: begin
				if (tbl_da_q[NW] && tbl_db_q[NW] && tbl_da_q != tbl_db_q) begin
					p_d = tbl_da_q[NW-1:0];
					q_d = tbl_db_q[NW-1:0];
				end
				if (lvl_q == '0) begin
					state_d = S_Q_FIN;
				end else begin
					lvl_d   = LW'(lvl_q - LW'(1));
					state_d = S_Q_UPB;
				end
			end
			S_Q_FIN: begin
				tbl_ra  = {LW'(0), p_q};
				tbl_rb  = {LW'(0), q_q};
				state_d = S_Q_FINW;
			end
			S_Q_FINW: begin
				if (tbl_da_q[NW] && tbl_da_q == tbl_db_q) begin
					res_d = tbl_da_q[NW-1:0];
					ok_d  = 1'b1;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CNT_RESET;
			built_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cfg_q <= cfg.data;
			end
			built_q <= built_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q    <= p_d;
		q_q    <= q_d;
		diff_q <= diff_d;
		lvl_q  <= lvl_d;
		gd_q   <= gd_d;
		bi_q   <= bi_d;
		bj_q   <= bj_d;
		res_q  <= res_d;
		ok_q   <= ok_d;
		if (rsp_load) begin
			rsp_anc_q   <= ok_q ? NODE_W'(res_q) : '0;
			rsp_found_q <= ok_q;
		end
	end

	// ancestor table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_da_q <= tbl_mem[tbl_ra];
		tbl_db_q <= tbl_mem[tbl_rb];
	end

	// depth store
	always_ff @(posedge clk) begin
		if (dep_we) begin
			dep_mem[NW'(req.first_node)] <= req.node_depth;
		end
		dep_dp_q <= dep_mem[p_q];
		dep_dq_q <= dep_mem[q_q];
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.ancestor = rsp_anc_q;
	assign rsp.found    = rsp_found_q;

endmodule
